@@ rtl/kct_pkg.sv @@
// kct_pkg: field widths, codes and controller/datapath interface types
// for the keyed counter table. No dependencies.
package kct_pkg;

	// field widths
	localparam int KEY_W  = 24;
	localparam int CNT_W  = 16;
	localparam int STAT_W = 2;
	localparam int EIDX_W = 4;
	localparam int SEL_W  = 2;
	localparam int CAP_W  = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

	// counter slots of one entry
	localparam logic [SEL_W-1:0] LAST_SLOT = 2'd2;

	// result kinds chosen by the controller
	localparam logic [1:0] RES_OK_VAL = 2'd0;
	localparam logic [1:0] RES_OK_MEM = 2'd1;
	localparam logic [1:0] RES_FULL   = 2'd2;
	localparam logic [1:0] RES_MISS   = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic       load_req;
		logic       search;
		logic       use_sel;
		logic       cnt_write;
		logic       cnt_read;
		logic       key_write;
		logic       idx_from_occ;
		logic       slot_inc;
		logic       occ_inc;
		logic       load_out;
		logic [1:0] res_kind;
	} kct_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic match;
		logic search_miss;
		logic is_read;
		logic at_limit;
		logic slot_last;
		logic out_free;
	} kct_stat_t;

endpackage

@@ rtl/kct_datapath.sv @@
// kct_datapath: request registers, key and counter memories, search
// pointer, occupancy and capacity registers, result register.
// Depends on kct_pkg; driven by kct_ctrl.
module kct_datapath import kct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kct_cmd_t          cmd,
	output kct_stat_t         stat,
	input  logic              cfg_valid,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic              req_type,
	input  logic [KEY_W-1:0]  key,
	input  logic [SEL_W-1:0]  counter_select,
	input  logic [CNT_W-1:0]  new_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [EIDX_W-1:0] entry_index,
	output logic [CNT_W-1:0]  counter_value
);

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCW  = $clog2(ENTRIES + 1);
	localparam int CAW  = $clog2(3 * ENTRIES);
	localparam int CMPW = (OCW > CAP_W) ? OCW : CAP_W;

	// memories
	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [CNT_W-1:0] cnt_mem [3 * ENTRIES];

	// control registers
	logic [CAP_W-1:0] cap_q;
	logic [OCW-1:0]   occ_q;
	logic             cmp_valid_q;
	logic             out_valid_q;

	// payload registers
	logic             is_read_q;
	logic [KEY_W-1:0] key_q;
	logic [SEL_W-1:0] sel_q;
	logic [CNT_W-1:0] val_q;
	logic [OCW-1:0]   ptr_q;
	logic [IW-1:0]    cmp_idx_q;
	logic [KEY_W-1:0] key_rd_q;
	logic [IW-1:0]    work_idx_q;
	logic [SEL_W-1:0] slot_q;
	logic [CNT_W-1:0] cnt_rd_q;
	logic [STAT_W-1:0] out_status_q;
	logic [EIDX_W-1:0] out_idx_q;
	logic [CNT_W-1:0]  out_value_q;

	logic             ptr_in_range;
	logic [IW-1:0]    ptr_idx;
	logic [IW-1:0]    occ_idx;
	logic [CMPW-1:0]  cap_ext;
	logic [CMPW-1:0]  ent_ext;
	logic [CMPW-1:0]  occ_ext;
	logic [CMPW-1:0]  limit;
	logic [SEL_W-1:0] slot;
	logic [CAW-1:0]   idx_ext;
	logic [CAW-1:0]   cnt_addr;
	logic [CNT_W-1:0] cnt_wdata;
	logic             key_hit;

	// search pointer and occupancy views
	assign ptr_in_range = (ptr_q < occ_q);
	assign ptr_idx      = ptr_q[IW-1:0];
	assign occ_idx      = occ_q[IW-1:0];
	assign key_hit      = cmp_valid_q && (key_rd_q == key_q);

	// effective limit is the smaller of capacity and table depth
	assign cap_ext = CMPW'(cap_q);
	assign ent_ext = CMPW'(ENTRIES);
	assign occ_ext = CMPW'(occ_q);
	assign limit   = (cap_ext < ent_ext) ? cap_ext : ent_ext;

	// counter address: entry * 3 + slot
	assign slot      = cmd.use_sel ? sel_q : slot_q;
	assign idx_ext   = CAW'(work_idx_q);
	assign cnt_addr  = (idx_ext << 1) + idx_ext + CAW'(slot);
	assign cnt_wdata = (slot == sel_q) ? val_q : '0;

	// status to controller
	always_comb begin
		stat.match       = key_hit;
		stat.search_miss = !cmp_valid_q && !ptr_in_range;
		stat.is_read     = is_read_q;
		stat.at_limit    = (occ_ext >= limit);
		stat.slot_last   = (slot_q == LAST_SLOT);
		stat.out_free    = !out_valid_q || out_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			cmp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.occ_inc) begin
				occ_q <= occ_q + 1'b1;
			end
			if (cmd.load_req) begin
				cmp_valid_q <= 1'b0;
			end else begin
				cmp_valid_q <= cmd.search && ptr_in_range;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, search pointer, slot counter, working index
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			is_read_q <= req_type;
			key_q     <= key;
			// select three saturates to the third counter
			sel_q     <= (counter_select > LAST_SLOT) ? LAST_SLOT : counter_select;
			val_q     <= new_value;
			ptr_q     <= '0;
			slot_q    <= '0;
		end else begin
			if (cmd.search && ptr_in_range) begin
				ptr_q     <= ptr_q + 1'b1;
				cmp_idx_q <= ptr_idx;
			end
			if (cmd.slot_inc) begin
				slot_q <= slot_q + 1'b1;
			end
		end
		if (cmd.search && key_hit) begin
			work_idx_q <= cmp_idx_q;
		end else if (cmd.idx_from_occ) begin
			work_idx_q <= occ_idx;
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (cmd.key_write) begin
			key_mem[occ_idx] <= key_q;
		end
		if (cmd.search && ptr_in_range) begin
			key_rd_q <= key_mem[ptr_idx];
		end
	end

	// counter memory
	always_ff @(posedge clk) begin
		if (cmd.cnt_write) begin
			cnt_mem[cnt_addr] <= cnt_wdata;
		end
		if (cmd.cnt_read) begin
			cnt_rd_q <= cnt_mem[cnt_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.res_kind)
				RES_OK_VAL: begin
					out_status_q <= ST_OK;
					out_idx_q    <= EIDX_W'(work_idx_q);
					out_value_q  <= val_q;
				end
				RES_OK_MEM: begin
					out_status_q <= ST_OK;
					out_idx_q    <= EIDX_W'(work_idx_q);
					out_value_q  <= cnt_rd_q;
				end
				RES_FULL: begin
					out_status_q <= ST_FULL;
					out_idx_q    <= '0;
					out_value_q  <= '0;
				end
				default: begin
					out_status_q <= ST_MISSING;
					out_idx_q    <= '0;
					out_value_q  <= '0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign entry_index   = out_idx_q;
	assign counter_value = out_value_q;

endmodule

@@ rtl/kct_ctrl.sv @@
// kct_ctrl: request sequencer for the keyed counter table.
// Depends on kct_pkg; commands kct_datapath.
module kct_ctrl import kct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  kct_stat_t stat,
	output kct_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_HIT    = 3'd2;
	localparam logic [2:0] S_MISS   = 3'd3;
	localparam logic [2:0] S_INSERT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] res_kind_q;
	logic [1:0] res_kind_d;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		res_kind_d   = res_kind_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.res_kind = res_kind_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.match) begin
					state_d = S_HIT;
				end else if (stat.search_miss) begin
					state_d = S_MISS;
				end
			end
			S_HIT: begin
				cmd.use_sel = 1'b1;
				if (stat.is_read) begin
					cmd.cnt_read = 1'b1;
					res_kind_d   = RES_OK_MEM;
				end else begin
					cmd.cnt_write = 1'b1;
					res_kind_d    = RES_OK_VAL;
				end
				state_d = S_DONE;
			end
			S_MISS: begin
				if (stat.is_read) begin
					res_kind_d = RES_MISS;
					state_d    = S_DONE;
				end else if (stat.at_limit) begin
					res_kind_d = RES_FULL;
					state_d    = S_DONE;
				end else begin
					cmd.key_write    = 1'b1;
					cmd.idx_from_occ = 1'b1;
					state_d          = S_INSERT;
				end
			end
			S_INSERT: begin
				// clear all three counters, selected one takes the value
				cmd.cnt_write = 1'b1;
				cmd.slot_inc  = 1'b1;
				if (stat.slot_last) begin
					cmd.occ_inc = 1'b1;
					res_kind_d  = RES_OK_VAL;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_kind_q <= RES_OK_VAL;
		end else begin
			state_q    <= state_d;
			res_kind_q <= res_kind_d;
		end
	end

endmodule

@@ rtl/keyed_counter_table.sv @@
// keyed_counter_table: top level, joins the sequencer and the datapath.
// Depends on kct_pkg, kct_ctrl and kct_datapath.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the capacity register;
//   cfg_ready is always high. Write it only while the table is idle.
//   in channel carries one request transaction: req_type, key,
//   counter_select, new_value. out channel returns one result transaction
//   per request: status, entry_index, counter_value.
// Timing:
//   one request at a time. The search compares the stored keys in order from
//   entry 0 and ends on a hit or once all occupied entries are compared; an
//   insert then writes the key and clears the three counters, one by one,
//   through the single counter memory port. The search reads one stored key
//   per cycle.
// Reset:
//   clears the occupied count and sets capacity to 16; the key and counter
//   memories are not cleared, only occupied entries are ever read.
// Stall:
//   a finished result waits in the output register; the next request is
//   accepted meanwhile and is held at its end until the register frees.
module keyed_counter_table import kct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [KEY_W-1:0]  key,
	input  logic [SEL_W-1:0]  counter_select,
	input  logic [CNT_W-1:0]  new_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [EIDX_W-1:0] entry_index,
	output logic [CNT_W-1:0]  counter_value
);

	kct_cmd_t  cmd;
	kct_stat_t stat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	kct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kct_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.key            (key),
		.counter_select (counter_select),
		.new_value      (new_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.entry_index    (entry_index),
		.counter_value  (counter_value)
	);

endmodule

@@ rtl/kct_checker.sv @@
// kct_checker: port-level assertions for keyed_counter_table, bound to it.
// Depends on kct_pkg.
module kct_checker import kct_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [EIDX_W-1:0] entry_index,
	input logic [CNT_W-1:0]  counter_value
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(entry_index) && $stable(counter_value))
		else $error("stalled result changed");

	// only the three defined status codes appear
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_MISSING))
		else $error("illegal status code");

	// errors report zero index and zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> entry_index == '0 && counter_value == '0)
		else $error("error result with nonzero fields");

	// one request at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

endmodule

bind keyed_counter_table kct_checker u_kct_checker (.*);
